[rtl/core/icfb_pkg.sv]
package icfb_pkg;

    localparam int NUM_FIFOS  = 4;
    localparam int FIFO_DEPTH = 16;

    localparam int IDX_W  = (NUM_FIFOS > 1) ? $clog2(NUM_FIFOS) : 1;
    localparam int PTR_W  = $clog2(FIFO_DEPTH);
    localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
    localparam int WORDS  = NUM_FIFOS * FIFO_DEPTH;
    localparam int ADDR_W = $clog2(WORDS);

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_POP   = 2'd1;
    localparam logic [1:0] KIND_PUSH  = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_INDEX = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;
    localparam logic [1:0] STATUS_FULL  = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  fifo_sel;
        logic [31:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_data;
        logic [31:0] lost_total;
    } t_out_item;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       wr_data;
    } t_ram_req;

endpackage

[rtl/core/icfb_word_ram.sv]
module icfb_word_ram (
    input  logic              i_clk,
    input  icfb_pkg::t_ram_req i_req,
    output logic [31:0]       o_rd_data
);

    logic [31:0] r_mem [icfb_pkg::WORDS];
    logic [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/indexed_circular_fifo_bank_core.sv]
// bank of independent circular fifos sharing one word memory
// input channel: i_in_valid / o_in_stall carry one request (clear, pop or push
// plus a fifo index and a push word); output channel: o_out_valid /
// i_out_stall carry exactly one result per request, in request order
// path: a request is taken in the pointer/count stage with the memory access,
// is held in the middle stage, then in the output register; throughput is one
// request per cycle while the receiver does not stall, set by the single port
// of the word memory, which each request uses at most once
// per-fifo pointers, fill counts and lost counters sit in registers and are
// updated in the cycle the request is taken, so back-to-back requests to the
// same fifo see each other without any hold-off
// reset (synchronous, active low) empties every fifo and zeroes every lost
// counter; the word memory itself is not cleared, entries are only read after
// a push has written them
// when the receiver stalls, the output register holds its result, the middle
// stage fills, and o_in_stall rises until the output moves again
module indexed_circular_fifo_bank_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  icfb_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output icfb_pkg::t_out_item o_out_data
);

    localparam int IDX_W  = icfb_pkg::IDX_W;
    localparam int PTR_W  = icfb_pkg::PTR_W;
    localparam int CNT_W  = icfb_pkg::CNT_W;
    localparam int ADDR_W = icfb_pkg::ADDR_W;

    logic [PTR_W-1:0] r_rd_ptr [icfb_pkg::NUM_FIFOS];
    logic [PTR_W-1:0] r_wr_ptr [icfb_pkg::NUM_FIFOS];
    logic [CNT_W-1:0] r_fill   [icfb_pkg::NUM_FIFOS];
    logic [31:0]      r_lost   [icfb_pkg::NUM_FIFOS];

    logic             in_acc;
    logic             idx_bad;
    logic [IDX_W-1:0] idx;
    logic [PTR_W-1:0] cur_rd, cur_wr, n_rd_ptr, n_wr_ptr;
    logic [CNT_W-1:0] cur_fill, n_fill;
    logic [31:0]      cur_lost, n_lost;
    logic [1:0]       status;
    logic             pop_ok;
    logic [31:0]      lost_total;
    icfb_pkg::t_ram_req ram_req;
    logic [31:0]      ram_q;
    logic [ADDR_W-1:0] base_addr;

    logic             r_s1_valid;
    logic [1:0]       r_s1_status;
    logic             r_s1_pop_ok;
    logic [31:0]      r_s1_lost;
    logic             r_out_valid;
    icfb_pkg::t_out_item r_out;
    logic             out_free;
    logic             s1_move;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_move    = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign idx_bad  = i_in_data.fifo_sel >= 8'(icfb_pkg::NUM_FIFOS);
    assign idx      = i_in_data.fifo_sel[IDX_W-1:0];
    assign cur_rd   = r_rd_ptr[idx];
    assign cur_wr   = r_wr_ptr[idx];
    assign cur_fill = r_fill[idx];
    assign cur_lost = r_lost[idx];
    assign base_addr = ADDR_W'(ADDR_W'(idx) * ADDR_W'(icfb_pkg::FIFO_DEPTH));

    always_comb begin
        n_rd_ptr = cur_rd;
        n_wr_ptr = cur_wr;
        n_fill   = cur_fill;
        n_lost   = cur_lost;
        status   = icfb_pkg::STATUS_OK;
        pop_ok   = 1'b0;
        ram_req  = '0;
        ram_req.wr_data = i_in_data.write_data;
        if (idx_bad) begin
            status = icfb_pkg::STATUS_INDEX;
        end else begin
            unique case (i_in_data.kind)
                icfb_pkg::KIND_CLEAR: begin
                    n_rd_ptr = '0;
                    n_wr_ptr = '0;
                    n_fill   = '0;
                    n_lost   = '0;
                end
                icfb_pkg::KIND_POP: begin
                    if (cur_fill == '0) begin
                        status = icfb_pkg::STATUS_EMPTY;
                    end else begin
                        pop_ok        = 1'b1;
                        ram_req.rd_en = in_acc;
                        ram_req.addr  = base_addr + ADDR_W'(cur_rd);
                        n_rd_ptr = (cur_rd == PTR_W'(icfb_pkg::FIFO_DEPTH - 1)) ?
                                   '0 : cur_rd + 1'b1;
                        n_fill   = cur_fill - 1'b1;
                    end
                end
                icfb_pkg::KIND_PUSH: begin
                    if (cur_fill == CNT_W'(icfb_pkg::FIFO_DEPTH)) begin
                        status = icfb_pkg::STATUS_FULL;
                        n_lost = cur_lost + 32'd1;
                    end else begin
                        ram_req.wr_en = in_acc;
                        ram_req.addr  = base_addr + ADDR_W'(cur_wr);
                        n_wr_ptr = (cur_wr == PTR_W'(icfb_pkg::FIFO_DEPTH - 1)) ?
                                   '0 : cur_wr + 1'b1;
                        n_fill   = cur_fill + 1'b1;
                    end
                end
                default: begin
                    // unused kind: no change, report the counter
                end
            endcase
        end
        lost_total = idx_bad ? 32'd0 : n_lost;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int f = 0; f < icfb_pkg::NUM_FIFOS; f++) begin
                r_rd_ptr[f] <= '0;
                r_wr_ptr[f] <= '0;
                r_fill[f]   <= '0;
                r_lost[f]   <= '0;
            end
        end else if (in_acc && !idx_bad) begin
            r_rd_ptr[idx] <= n_rd_ptr;
            r_wr_ptr[idx] <= n_wr_ptr;
            r_fill[idx]   <= n_fill;
            r_lost[idx]   <= n_lost;
        end
    end

    icfb_word_ram u_word_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (ram_q)
    );

    // middle stage waits for the memory read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_status <= status;
            r_s1_pop_ok <= pop_ok;
            r_s1_lost   <= lost_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out.status     <= r_s1_status;
            r_out.read_data  <= r_s1_pop_ok ? ram_q : 32'd0;
            r_out.lost_total <= r_s1_lost;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_full_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !idx_bad && i_in_data.kind == icfb_pkg::KIND_PUSH &&
         cur_fill == CNT_W'(icfb_pkg::FIFO_DEPTH))
        |=> r_lost[$past(idx)] == $past(cur_lost) + 32'd1)
        else $error("full push did not advance lost counter");

    a_pop_reaches_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && pop_ok)
        |=> (r_s1_valid && r_s1_pop_ok && r_s1_status == icfb_pkg::STATUS_OK))
        else $error("successful pop lost before middle stage");

    a_bad_index_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && idx_bad)
        |=> (r_s1_status == icfb_pkg::STATUS_INDEX && r_s1_lost == 32'd0 &&
             !r_s1_pop_ok))
        else $error("bad index result not clean");

    // read data only matters for a pop; otherwise the memory output may be unknown
    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_free)
        |=> (r_s1_valid && $stable(r_s1_lost) && $stable(r_s1_status) &&
             (!r_s1_pop_ok || $stable(ram_q))))
        else $error("middle stage changed while output blocked");

endmodule

[sim/tb_indexed_circular_fifo_bank_core.sv]
`timescale 1ns / 100ps

module tb_indexed_circular_fifo_bank_core;

    // kind value three is unused by the block; it must leave every fifo untouched
    localparam logic [1:0] KIND_SPARE = 2'd3;

    localparam int N_RANDOM   = 1300;
    localparam int N_ROWS     = 22;
    localparam int HOLD_LEN   = 80;
    localparam int DRAIN_WAIT = 6;
    localparam int CYCLE_CAP  = 100000;

    typedef struct {
        logic [1:0]          kind;
        logic [7:0]          fifo_sel;
        logic [31:0]         data;
        int                  reps;
        bit                  typed;
        icfb_pkg::t_out_item want;
    } t_row;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    icfb_pkg::t_in_item  in_data   = '0;
    logic                out_stall = 1'b0;
    logic                in_stall;
    logic                out_valid;
    icfb_pkg::t_out_item out_data;

    logic [1:0] phase     = 2'd0;
    logic       hold_req  = 1'b0;
    logic       hold_done = 1'b0;
    int         hold_left = 0;
    int         n_errors  = 0;
    int         n_checked = 0;
    int         cycles    = 0;

    // shadow copy of the bank
    logic [31:0]                words [icfb_pkg::NUM_FIFOS][icfb_pkg::FIFO_DEPTH];
    logic [icfb_pkg::PTR_W-1:0] rd_ptr [icfb_pkg::NUM_FIFOS];
    logic [icfb_pkg::PTR_W-1:0] wr_ptr [icfb_pkg::NUM_FIFOS];
    logic [icfb_pkg::CNT_W-1:0] fill [icfb_pkg::NUM_FIFOS];
    logic [31:0]                lost [icfb_pkg::NUM_FIFOS];

    icfb_pkg::t_out_item fifo_replies_due [$];
    icfb_pkg::t_in_item  stim_q [$];
    bit                  stim_typed [$];
    icfb_pkg::t_out_item stim_want [$];
    t_row                dir_rows [N_ROWS];

    indexed_circular_fifo_bank_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
    end

    function automatic logic [icfb_pkg::PTR_W-1:0] ptr_next(
        input logic [icfb_pkg::PTR_W-1:0] p);
        return (p == icfb_pkg::FIFO_DEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    function automatic icfb_pkg::t_out_item fifo_bank_apply(input icfb_pkg::t_in_item req);
        icfb_pkg::t_out_item r;
        int                  f;
        r.status    = icfb_pkg::STATUS_OK;
        r.read_data = '0;
        r.lost_total = '0;
        // bad index is rejected before any state is looked at
        if (req.fifo_sel >= icfb_pkg::NUM_FIFOS) begin
            r.status = icfb_pkg::STATUS_INDEX;
            return r;
        end
        f = int'(req.fifo_sel);
        case (req.kind)
            icfb_pkg::KIND_CLEAR: begin
                rd_ptr[f] = '0;
                wr_ptr[f] = '0;
                fill[f]   = '0;
                lost[f]   = '0;
            end
            icfb_pkg::KIND_POP: begin
                if (fill[f] == 0) begin
                    r.status = icfb_pkg::STATUS_EMPTY;
                end else begin
                    r.read_data = words[f][rd_ptr[f]];
                    rd_ptr[f]   = ptr_next(rd_ptr[f]);
                    fill[f]     = fill[f] - 1'b1;
                end
            end
            icfb_pkg::KIND_PUSH: begin
                if (fill[f] == icfb_pkg::FIFO_DEPTH) begin
                    r.status = icfb_pkg::STATUS_FULL;
                    lost[f]  = lost[f] + 1'b1;
                end else begin
                    words[f][wr_ptr[f]] = req.write_data;
                    wr_ptr[f] = ptr_next(wr_ptr[f]);
                    fill[f]   = fill[f] + 1'b1;
                end
            end
            default: ;
        endcase
        r.lost_total = lost[f];
        return r;
    endfunction

    // receiver: random stall in phases 0 and 1, none in phase 2 but one long hold-off at its start
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            out_stall <= 1'b1;
        end else if (hold_left > 1) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            hold_left <= 0;
            case (phase)
                2'd0:    out_stall <= ($urandom_range(99) < 76);
                2'd1:    out_stall <= ($urandom_range(99) < 21);
                default: out_stall <= 1'b0;
            endcase
        end
    end

    always @(posedge clk) begin : check_replies
        icfb_pkg::t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (fifo_replies_due.size() == 0) begin
                $display("%0t: unexpected result, got %h", $time, out_data);
                n_errors = n_errors + 1;
            end else begin
                want = fifo_replies_due.pop_front();
                n_checked = n_checked + 1;
                if (out_data.status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, out_data.status);
                    n_errors = n_errors + 1;
                end
                if (out_data.read_data !== want.read_data) begin
                    $display("%0t: read_data mismatch, expected %h, got %h",
                             $time, want.read_data, out_data.read_data);
                    n_errors = n_errors + 1;
                end
                if (out_data.lost_total !== want.lost_total) begin
                    $display("%0t: lost_total mismatch, expected %0d, got %0d",
                             $time, want.lost_total, out_data.lost_total);
                    n_errors = n_errors + 1;
                end
            end
        end
    end

    initial begin
        repeat (CYCLE_CAP) @(posedge clk);
        $display("timeout after %0d cycles, %0d results still due",
                 CYCLE_CAP, fifo_replies_due.size());
        $display("FAIL");
        $finish;
    end

    initial begin : run
        icfb_pkg::t_in_item  it;
        icfb_pkg::t_in_item  nd;
        icfb_pkg::t_out_item got;
        logic                nv;
        int                  n_items;
        int                  n_directed;
        int                  n_sent;
        int                  b1;
        int                  b2;
        int                  send_idle;
        int                  burst_left;
        int                  mode;
        int                  focus;
        int                  roll;
        int                  push_pct;
        int                  n_full;
        int                  n_empty;
        int                  n_bad;

        foreach (rd_ptr[f]) begin
            rd_ptr[f] = '0;
            wr_ptr[f] = '0;
            fill[f]   = '0;
            lost[f]   = '0;
        end

        dir_rows = '{
            '{icfb_pkg::KIND_POP,   8'd0,   32'h0,        1,  1'b1,
              '{icfb_pkg::STATUS_EMPTY, 32'h0, 32'h0}},
            '{icfb_pkg::KIND_CLEAR, 8'd3,   32'h0,        1,  1'b1,
              '{icfb_pkg::STATUS_OK,    32'h0, 32'h0}},
            '{icfb_pkg::KIND_PUSH,  8'd4,   32'hFFFFFFFF, 1,  1'b1,
              '{icfb_pkg::STATUS_INDEX, 32'h0, 32'h0}},
            '{icfb_pkg::KIND_POP,   8'd255, 32'h0,        1,  1'b1,
              '{icfb_pkg::STATUS_INDEX, 32'h0, 32'h0}},
            '{KIND_SPARE,           8'd1,   32'h0,        1,  1'b1,
              '{icfb_pkg::STATUS_OK,    32'h0, 32'h0}},
            '{KIND_SPARE,           8'd128, 32'h0,        1,  1'b1,
              '{icfb_pkg::STATUS_INDEX, 32'h0, 32'h0}},
            '{icfb_pkg::KIND_CLEAR, 8'd170, 32'h0,        1,  1'b1,
              '{icfb_pkg::STATUS_INDEX, 32'h0, 32'h0}},
            '{icfb_pkg::KIND_PUSH,  8'd0,   32'hFFFFFFFF, 1,  1'b1,
              '{icfb_pkg::STATUS_OK,    32'h0, 32'h0}},
            '{icfb_pkg::KIND_PUSH,  8'd0,   32'h00000000, 1,  1'b1,
              '{icfb_pkg::STATUS_OK,    32'h0, 32'h0}},
            '{icfb_pkg::KIND_POP,   8'd0,   32'h0,        1,  1'b1,
              '{icfb_pkg::STATUS_OK, 32'hFFFFFFFF, 32'h0}},
            '{icfb_pkg::KIND_POP,   8'd0,   32'h0,        1,  1'b1,
              '{icfb_pkg::STATUS_OK,    32'h0, 32'h0}},
            '{icfb_pkg::KIND_POP,   8'd0,   32'h0,        1,  1'b1,
              '{icfb_pkg::STATUS_EMPTY, 32'h0, 32'h0}},
            '{icfb_pkg::KIND_PUSH,  8'd2,   32'hA5A50000, 16, 1'b0,
              '{icfb_pkg::STATUS_OK,    32'h0, 32'h0}},
            '{icfb_pkg::KIND_PUSH,  8'd2,   32'h12345678, 1,  1'b1,
              '{icfb_pkg::STATUS_FULL,  32'h0, 32'd1}},
            '{icfb_pkg::KIND_PUSH,  8'd2,   32'h87654321, 1,  1'b1,
              '{icfb_pkg::STATUS_FULL,  32'h0, 32'd2}},
            '{icfb_pkg::KIND_POP,   8'd2,   32'h0,        1,  1'b1,
              '{icfb_pkg::STATUS_OK, 32'hA5A50000, 32'd2}},
            // write pointer has already wrapped back to entry zero; this push reuses it
            '{icfb_pkg::KIND_PUSH,  8'd2,   32'hDEADBEEF, 1,  1'b1,
              '{icfb_pkg::STATUS_OK,    32'h0, 32'd2}},
            '{KIND_SPARE,           8'd2,   32'h0,        1,  1'b1,
              '{icfb_pkg::STATUS_OK,    32'h0, 32'd2}},
            '{icfb_pkg::KIND_CLEAR, 8'd2,   32'h0,        1,  1'b1,
              '{icfb_pkg::STATUS_OK,    32'h0, 32'h0}},
            '{icfb_pkg::KIND_POP,   8'd2,   32'h0,        1,  1'b1,
              '{icfb_pkg::STATUS_EMPTY, 32'h0, 32'h0}},
            '{icfb_pkg::KIND_PUSH,  8'd1,   32'h55AA55AA, 1,  1'b1,
              '{icfb_pkg::STATUS_OK,    32'h0, 32'h0}},
            '{icfb_pkg::KIND_POP,   8'd1,   32'h0,        1,  1'b1,
              '{icfb_pkg::STATUS_OK, 32'h55AA55AA, 32'h0}}
        };

        foreach (dir_rows[r]) begin
            for (int k = 0; k < dir_rows[r].reps; k++) begin
                it.kind       = dir_rows[r].kind;
                it.fifo_sel   = dir_rows[r].fifo_sel;
                it.write_data = 32'(dir_rows[r].data + k);
                stim_q.push_back(it);
                stim_typed.push_back(dir_rows[r].typed);
                stim_want.push_back(dir_rows[r].want);
            end
        end
        n_directed = stim_q.size();

        // random part: bursts that lean toward push or pop, or mix both evenly, on one focus fifo,
        // so fifos actually fill up and drain, with some noise mixed in
        burst_left = 0;
        mode       = 0;
        focus      = 0;
        for (int k = 0; k < N_RANDOM; k++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(40, 8);
                mode       = $urandom_range(2);
                focus      = $urandom_range(icfb_pkg::NUM_FIFOS - 1);
            end
            burst_left    = burst_left - 1;
            it.write_data = $urandom();
            roll = $urandom_range(99);
            if (roll < 6)
                it.fifo_sel = 8'($urandom_range(255, icfb_pkg::NUM_FIFOS));
            else if (roll < 60)
                it.fifo_sel = 8'(focus);
            else
                it.fifo_sel = 8'($urandom_range(icfb_pkg::NUM_FIFOS - 1));
            push_pct = (mode == 0) ? 75 : (mode == 1) ? 20 : 50;
            roll = $urandom_range(99);
            if (roll < 2)
                it.kind = icfb_pkg::KIND_CLEAR;
            else if (roll < 4)
                it.kind = KIND_SPARE;
            else if ($urandom_range(99) < push_pct)
                it.kind = icfb_pkg::KIND_PUSH;
            else
                it.kind = icfb_pkg::KIND_POP;
            stim_q.push_back(it);
            stim_typed.push_back(1'b0);
            stim_want.push_back('0);
        end

        n_items = stim_q.size();
        b1      = n_directed + N_RANDOM / 3;
        b2      = n_directed + (2 * N_RANDOM) / 3;
        n_sent  = 0;
        n_full  = 0;
        n_empty = 0;
        n_bad   = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (n_sent < n_items) begin
            @(posedge clk);
            nv = in_valid;
            nd = in_data;
            if (in_valid && !in_stall) begin
                got = fifo_bank_apply(in_data);
                case (got.status)
                    icfb_pkg::STATUS_FULL:  n_full  = n_full + 1;
                    icfb_pkg::STATUS_EMPTY: n_empty = n_empty + 1;
                    icfb_pkg::STATUS_INDEX: n_bad   = n_bad + 1;
                    default: ;
                endcase
                if (stim_typed[n_sent])
                    fifo_replies_due.push_back(stim_want[n_sent]);
                else
                    fifo_replies_due.push_back(got);
                n_sent = n_sent + 1;
                nv = 1'b0;
            end
            send_idle = (n_sent >= b2) ? 0 : (n_sent >= b1) ? 76 : 21;
            if (!nv && n_sent < n_items && $urandom_range(99) >= send_idle) begin
                nv = 1'b1;
                nd = stim_q[n_sent];
            end
            in_valid <= nv;
            in_data  <= nd;
            phase    <= (n_sent >= b2) ? 2'd2 : (n_sent >= b1) ? 2'd1 : 2'd0;
            hold_req <= (n_sent >= b2);
        end

        while (fifo_replies_due.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("%0d requests (%0d directed), %0d results checked in %0d cycles",
                 n_items, n_directed, n_checked, cycles);
        $display("full pushes %0d, empty pops %0d, bad indexes %0d, mismatches %0d",
                 n_full, n_empty, n_bad, n_errors);
        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
